/* rtl/utf8_decoder_with_invalid_escape_top_macros.svh */
// Assertion macros shared by the UTF-8 decoder RTL.
// No dependencies; included by files that carry assertions.
`ifndef UTF8_DECODER_WITH_INVALID_ESCAPE_TOP_MACROS_SVH
`define UTF8_DECODER_WITH_INVALID_ESCAPE_TOP_MACROS_SVH

// Same-cycle check, clocked on clk_i, off during reset.
`define UDEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle check: when cond holds, prop must hold in the next cycle.
`define UDEC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/udec_pkg.sv */
// Types and constants for the UTF-8 decoder with escape of invalid bytes.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package udec_pkg;

  localparam int unsigned RuneW = 31;
  localparam int unsigned CpW   = 21;

  localparam logic [RuneW-1:0] ESC_MARK = 31'h7000_0000;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam logic [CpW-1:0] CP_MIN2   = 21'h00_0080;
  localparam logic [CpW-1:0] CP_MAX2   = 21'h00_07ff;
  localparam logic [CpW-1:0] CP_MIN3   = 21'h00_0800;
  localparam logic [CpW-1:0] CP_SURR_LO = 21'h00_d7ff;
  localparam logic [CpW-1:0] CP_SURR_HI = 21'h00_e000;
  localparam logic [CpW-1:0] CP_MIN4   = 21'h01_0000;
  localparam logic [CpW-1:0] CP_MAX    = 21'h10_ffff;

  typedef logic [RuneW-1:0] rune_t;
  typedef logic [CpW-1:0]   cp_t;

endpackage

`default_nettype wire

/* rtl/udec_if.sv */
// Valid/ready channel interfaces for the UTF-8 decoder: byte in, rune out.
// Depends on udec_pkg.
`default_nettype none

interface udec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface udec_out_if;
  logic           valid;
  logic           ready;
  udec_pkg::rune_t rune;
  logic           run_last;
  logic           string_done;

  modport source (output valid, output rune, output run_last, output string_done, input ready);
  modport sink   (input valid, input rune, input run_last, input string_done, output ready);
endinterface

`default_nettype wire

/* rtl/utf8_decoder_with_invalid_escape_top.sv */
// A byte is captured in the input register; the runes it completes are then held in the result register.
// Throughput: one byte per cycle while the output is ready; a byte that gives more than one
// rune holds the input until the single result register has drained them, one rune per cycle.
// Reset (async, active low) clears the pending sequence and both stage valids.
// Top level of the UTF-8 decoder; depends on udec_pkg, udec_if and the macro header.
`default_nettype none
`include "utf8_decoder_with_invalid_escape_top_macros.svh"

module utf8_decoder_with_invalid_escape_top (
  input  wire            clk_i,
  input  wire            rst_ni,
  udec_in_if.sink        in_ch_i,
  udec_out_if.source     out_ch_o
);

  // input register
  logic       pipe_v_q;
  logic [7:0] pipe_byte_q;
  logic       pipe_end_q;

  // decoder state
  logic [7:0] held_q [3];
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [2:0] seq_len_q, seq_len_d;
  logic       held_we;
  logic [1:0] held_wa;

  // result register
  logic            out_v_q;
  logic [1:0]      cnt_q, idx_q;
  logic            esc_q, end_q;
  udec_pkg::cp_t   val_q;
  logic [7:0]      bytes_q [4];

  logic out_take, out_last, bundle_free, proc_fire;
  logic res_v, res_esc;
  logic [1:0] res_cnt;
  udec_pkg::cp_t res_val;

  logic [7:0] b;
  logic [7:0] seq [4];
  logic [2:0] lead_len;
  logic       complete;
  udec_pkg::cp_t v2, v3, v4;
  logic ok2, ok3, ok4, seq_ok;

  assign out_last    = (idx_q == cnt_q);
  assign out_take    = out_v_q && out_ch_o.ready;
  assign bundle_free = !out_v_q || (out_take && out_last);
  assign proc_fire   = pipe_v_q && bundle_free;
  assign in_ch_i.ready = !pipe_v_q || bundle_free;

  assign b      = pipe_byte_q;
  assign seq[0] = (held_cnt_q > 2'd0) ? held_q[0] : b;
  assign seq[1] = (held_cnt_q > 2'd1) ? held_q[1] : b;
  assign seq[2] = (held_cnt_q > 2'd2) ? held_q[2] : b;
  assign seq[3] = b;

  assign v2 = {10'b0, seq[0][4:0], seq[1][5:0]};
  assign v3 = {5'b0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
  assign v4 = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};

  assign ok2 = (seq[1][7:6] == 2'b10) && (v2 >= udec_pkg::CP_MIN2) && (v2 <= udec_pkg::CP_MAX2);
  assign ok3 = (seq[1][7:6] == 2'b10) && (seq[2][7:6] == 2'b10) &&
               (v3 >= udec_pkg::CP_MIN3) &&
               !((v3 > udec_pkg::CP_SURR_LO) && (v3 < udec_pkg::CP_SURR_HI));
  assign ok4 = (seq[1][7:6] == 2'b10) && (seq[2][7:6] == 2'b10) &&
               (seq[3][7:6] == 2'b10) &&
               (v4 >= udec_pkg::CP_MIN4) && (v4 <= udec_pkg::CP_MAX);

  assign complete = ({1'b0, held_cnt_q} + 3'd1) == seq_len_q;

  always_comb begin
    if (b[7:5] == 3'b110) begin
      lead_len = udec_pkg::SEQ_LEN2;
    end else if (b[7:4] == 4'b1110) begin
      lead_len = udec_pkg::SEQ_LEN3;
    end else if (b[7:3] == 5'b11110) begin
      lead_len = udec_pkg::SEQ_LEN4;
    end else begin
      lead_len = udec_pkg::SEQ_NONE;
    end
  end

  always_comb begin
    unique case (seq_len_q)
      udec_pkg::SEQ_LEN2: seq_ok = ok2;
      udec_pkg::SEQ_LEN3: seq_ok = ok3;
      default:            seq_ok = ok4;
    endcase
  end

  always_comb begin
    res_v      = 1'b0;
    res_esc    = 1'b1;
    res_val    = {2'b0, v4[18:0]};
    res_cnt    = held_cnt_q;
    held_we    = 1'b0;
    held_wa    = held_cnt_q;
    held_cnt_d = held_cnt_q;
    seq_len_d  = seq_len_q;
    if (seq_len_q == udec_pkg::SEQ_NONE) begin
      res_cnt = 2'd0;
      if (!b[7]) begin
        res_v   = 1'b1;
        res_esc = 1'b0;
        res_val = {13'b0, b};
      end else if (lead_len != udec_pkg::SEQ_NONE && !pipe_end_q) begin
        held_we    = 1'b1;
        held_wa    = 2'd0;
        held_cnt_d = 2'd1;
        seq_len_d  = lead_len;
      end else begin
        res_v = 1'b1;
      end
    end else if (complete) begin
      res_v      = 1'b1;
      held_cnt_d = 2'd0;
      seq_len_d  = udec_pkg::SEQ_NONE;
      if (seq_ok) begin
        res_esc = 1'b0;
        res_cnt = 2'd0;
        unique case (seq_len_q)
          udec_pkg::SEQ_LEN2: res_val = v2;
          udec_pkg::SEQ_LEN3: res_val = v3;
          default:            res_val = v4;
        endcase
      end
    end else if (pipe_end_q) begin
      res_v      = 1'b1;
      held_cnt_d = 2'd0;
      seq_len_d  = udec_pkg::SEQ_NONE;
    end else begin
      held_we    = 1'b1;
      held_cnt_d = held_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q   <= 1'b0;
      held_cnt_q <= 2'd0;
      seq_len_q  <= udec_pkg::SEQ_NONE;
      out_v_q    <= 1'b0;
      idx_q      <= 2'd0;
      cnt_q      <= 2'd0;
    end else begin
      if (in_ch_i.valid && in_ch_i.ready) begin
        pipe_v_q <= 1'b1;
      end else if (proc_fire) begin
        pipe_v_q <= 1'b0;
      end
      if (proc_fire) begin
        held_cnt_q <= held_cnt_d;
        seq_len_q  <= seq_len_d;
        out_v_q    <= res_v;
        idx_q      <= 2'd0;
        cnt_q      <= res_cnt;
      end else if (out_take) begin
        if (out_last) begin
          out_v_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_ch_i.ready) begin
      pipe_byte_q <= in_ch_i.in_byte;
      pipe_end_q  <= in_ch_i.string_end;
    end
    if (proc_fire && held_we) begin
      held_q[held_wa] <= b;
    end
    if (proc_fire && res_v) begin
      esc_q   <= res_esc;
      end_q   <= pipe_end_q;
      val_q   <= res_val;
      bytes_q <= seq;
    end
  end

  assign out_ch_o.valid       = out_v_q;
  assign out_ch_o.rune        = esc_q ? (udec_pkg::ESC_MARK | {23'b0, bytes_q[idx_q]})
                                      : {10'b0, val_q};
  assign out_ch_o.run_last    = out_last;
  assign out_ch_o.string_done = out_last && end_q;

  `UDEC_ASSERT(a_held_consistent, (seq_len_q == udec_pkg::SEQ_NONE) ? (held_cnt_q == 2'd0) : ((held_cnt_q != 2'd0) && ({1'b0, held_cnt_q} < seq_len_q)), "held count out of range for pending sequence")
  `UDEC_ASSERT(a_idx_bound, !out_v_q || (idx_q <= cnt_q), "rune index past last rune of item")
  `UDEC_ASSERT(a_decoded_single, !(out_v_q && !esc_q) || (cnt_q == 2'd0), "decoded code point must be a single rune")
  `UDEC_ASSERT_NEXT(a_end_idle, proc_fire && pipe_end_q, seq_len_q == udec_pkg::SEQ_NONE, "decoder not idle after end of string")

endmodule

`default_nettype wire
